[rtl/mtt_pkg.sv]
package mtt_pkg;

   localparam int TableDepth = 16;

   typedef enum logic [1:0] {
      OP_START_DIST  = 2'd0,
      OP_START_GIVEN = 2'd1,
      OP_TICK        = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_FINISHED = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  from_row;
      logic [3:0]  from_col;
      logic [3:0]  to_row;
      logic [3:0]  to_col;
      logic [7:0]  piece_id;
      logic [15:0] step_time;
      logic [3:0]  given_steps;
      logic [15:0] tick_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  out_from_row;
      logic [3:0]  out_from_col;
      logic [3:0]  out_to_row;
      logic [3:0]  out_to_col;
      logic [7:0]  out_piece_id;
      logic [19:0] out_total_time;
      logic [3:0]  out_steps;
      logic [15:0] out_step_time;
      logic        last;
   } rsp_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [15:0] cells;
      logic [7:0]  piece_id;
      logic [19:0] total;
      logic [19:0] elapsed;
      logic [3:0]  steps;
      logic [15:0] step_time;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE,
      ST_READ,
      ST_SCAN,
      ST_EMIT,
      ST_RESP,
      ST_LAST
   } state_type;

endpackage

[rtl/motion_timer_table.sv]
// motion timer table
// req channel: one beat per command (start with computed distance, start with
// given distance, tick). rsp channel: result beats, last marks the final beat
// caused by one command. valid/stall handshake on both channels.
// an accepted start takes the step count (distance or given) in ST_MUL, then
// multiplies by step time, writes the entry and loads its result in ST_WRITE.
// a start on a full table shows its rejected beat in the cycle after acceptance.
// a tick walks the table through the entry memory: each entry is read in ST_READ
// and updated in ST_SCAN, unfinished entries are written back compacted, and a
// finished beat is held until the next finished entry turns up, so each
// finished entry after the first goes through ST_EMIT and the last beat through
// ST_LAST. a tick on an empty table and op 3 end at once.
// one command is in work at a time; req_stall is high until it is done and
// its last beat has left the output register.
// reset clears the control registers only; the memory needs no clearing.
// with rsp_stall high the pending beat holds; a walk stalls in EMIT or LAST.
module motion_timer_table #(
   parameter int TABLE_DEPTH = mtt_pkg::TableDepth,
   parameter int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   parameter int CntW = $clog2(TABLE_DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtt_pkg::rsp_type rsp_data
);

   mtt_pkg::state_type state_ff, state_in;
   mtt_pkg::req_type   cmd_ff, cmd_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [CntW-1:0]    idx_ff, idx_in;
   logic [CntW-1:0]    keep_ff, keep_in;
   logic               found_ff, found_in;
   logic [3:0]         steps_ff, steps_in;
   mtt_pkg::entry_type cur_ff, cur_in;
   mtt_pkg::rsp_type   held_ff, held_in;
   logic               rvalid_ff, rvalid_in;
   mtt_pkg::rsp_type   rdata_ff, rdata_in;

   logic               wr_en;
   logic [AddrW-1:0]   wr_addr, rd_addr;
   mtt_pkg::entry_type wr_data, rd_data;

   logic [3:0]  dr, dc;
   logic [20:0] adv;
   logic [19:0] adv_sat;
   logic        done_now;
   logic        accept;

   // finished beat built from one entry
   function automatic mtt_pkg::rsp_type finished_beat(mtt_pkg::entry_type e);
      mtt_pkg::rsp_type r;
      r                = '0;
      r.kind           = mtt_pkg::KIND_FINISHED;
      r.out_from_row   = e.cells[15:12];
      r.out_from_col   = e.cells[11:8];
      r.out_to_row     = e.cells[7:4];
      r.out_to_col     = e.cells[3:0];
      r.out_piece_id   = e.piece_id;
      r.out_total_time = e.total;
      r.out_steps      = e.steps;
      r.out_step_time  = e.step_time;
      return r;
   endfunction

   mtt_mem #(.Depth(TABLE_DEPTH), .AddrW(AddrW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != mtt_pkg::ST_IDLE) || rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rdata_ff;

   // distance and advanced elapsed time
   always_comb begin
      dr = (cmd_ff.from_row >= cmd_ff.to_row) ? cmd_ff.from_row - cmd_ff.to_row
                                              : cmd_ff.to_row - cmd_ff.from_row;
      dc = (cmd_ff.from_col >= cmd_ff.to_col) ? cmd_ff.from_col - cmd_ff.to_col
                                              : cmd_ff.to_col - cmd_ff.from_col;
      adv = {1'b0, rd_data.elapsed} + {5'd0, cmd_ff.tick_time};
      adv_sat = (adv >= {1'b0, rd_data.total}) ? rd_data.total : adv[19:0];
      done_now = adv >= {1'b0, rd_data.total};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.op == mtt_pkg::OP_TICK) begin
                  state_in = (count_ff == '0) ? mtt_pkg::ST_IDLE : mtt_pkg::ST_READ;
               end else if (req_data.op == mtt_pkg::OP_NONE) begin
                  state_in = mtt_pkg::ST_IDLE;
               end else if (count_ff == CntW'(TABLE_DEPTH)) begin
                  state_in = mtt_pkg::ST_RESP;
               end else begin
                  state_in = mtt_pkg::ST_MUL;
               end
            end
         end
         mtt_pkg::ST_MUL:   state_in = mtt_pkg::ST_WRITE;
         mtt_pkg::ST_WRITE: state_in = mtt_pkg::ST_RESP;
         mtt_pkg::ST_RESP:  if (!rvalid_ff) state_in = mtt_pkg::ST_IDLE;
         mtt_pkg::ST_READ:  state_in = mtt_pkg::ST_SCAN;
         mtt_pkg::ST_SCAN: begin
            if (done_now && found_ff) begin
               state_in = mtt_pkg::ST_EMIT;
            end else if (idx_ff + 1'b1 == count_ff) begin
               state_in = (done_now || found_ff) ? mtt_pkg::ST_LAST : mtt_pkg::ST_IDLE;
            end else begin
               state_in = mtt_pkg::ST_READ;
            end
         end
         mtt_pkg::ST_EMIT: begin
            // the held beat waits for the output register
            if (!rvalid_ff || !rsp_stall) begin
               state_in = (idx_ff + 1'b1 == count_ff) ? mtt_pkg::ST_LAST
                                                      : mtt_pkg::ST_READ;
            end
         end
         mtt_pkg::ST_LAST: begin
            if (!rvalid_ff || !rsp_stall) state_in = mtt_pkg::ST_IDLE;
         end
         default: state_in = mtt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      keep_in   = keep_ff;
      found_in  = found_ff;
      steps_in  = steps_ff;
      cur_in    = cur_ff;
      held_in   = held_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rdata_in  = rdata_ff;
      wr_en     = 1'b0;
      wr_addr   = keep_ff[AddrW-1:0];
      wr_data   = cur_ff;
      rd_addr   = idx_ff[AddrW-1:0];
      case (state_ff)
         mtt_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_data;
               idx_in   = '0;
               keep_in  = '0;
               found_in = 1'b0;
               if ((req_data.op inside {mtt_pkg::OP_START_DIST, mtt_pkg::OP_START_GIVEN}) &&
                   count_ff == CntW'(TABLE_DEPTH)) begin
                  rvalid_in     = 1'b1;
                  rdata_in      = '0;
                  rdata_in.kind = mtt_pkg::KIND_REJECTED;
                  rdata_in.last = 1'b1;
               end
            end
         end
         mtt_pkg::ST_MUL: begin
            steps_in = (cmd_ff.op == mtt_pkg::OP_START_DIST) ?
                       ((dr > dc) ? dr : dc) : cmd_ff.given_steps;
         end
         mtt_pkg::ST_WRITE: begin
            wr_en             = 1'b1;
            wr_addr           = count_ff[AddrW-1:0];
            wr_data.cells     = {cmd_ff.from_row, cmd_ff.from_col,
                                 cmd_ff.to_row, cmd_ff.to_col};
            wr_data.piece_id  = cmd_ff.piece_id;
            wr_data.total     = 20'({4'd0, steps_ff} * {4'd0, cmd_ff.step_time});
            wr_data.elapsed   = '0;
            wr_data.steps     = steps_ff;
            wr_data.step_time = cmd_ff.step_time;
            count_in          = count_ff + 1'b1;
            rvalid_in         = 1'b1;
            rdata_in          = '0;
            rdata_in.kind     = mtt_pkg::KIND_ACCEPTED;
            rdata_in.last     = 1'b1;
         end
         mtt_pkg::ST_SCAN: begin
            // keep unfinished entries, compacted in place
            cur_in         = rd_data;
            cur_in.elapsed = adv_sat;
            if (done_now) begin
               // first finished entry is held, later ones go through emit
               if (!found_ff) begin
                  held_in  = finished_beat(cur_in);
                  found_in = 1'b1;
                  idx_in   = idx_ff + 1'b1;
               end
            end else begin
               wr_en           = 1'b1;
               wr_addr         = keep_ff[AddrW-1:0];
               wr_data         = rd_data;
               wr_data.elapsed = adv_sat;
               keep_in         = keep_ff + 1'b1;
               idx_in          = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == count_ff && !found_ff) begin
                  count_in = keep_ff + 1'b1;
               end
            end
         end
         mtt_pkg::ST_EMIT: begin
            // send the held beat and hold the new finished entry
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in = 1'b1;
               rdata_in  = held_ff;
               held_in   = finished_beat(cur_ff);
               idx_in    = idx_ff + 1'b1;
            end
         end
         mtt_pkg::ST_LAST: begin
            // the held beat ends the walk
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in     = 1'b1;
               rdata_in      = held_ff;
               rdata_in.last = 1'b1;
               found_in      = 1'b0;
               count_in      = keep_ff;
            end
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mtt_pkg::ST_IDLE;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
         found_ff  <= found_in;
      end
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      keep_ff  <= keep_in;
      steps_ff <= steps_in;
      cur_ff   <= cur_in;
      held_ff  <= held_in;
      rdata_ff <= rdata_in;
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(TABLE_DEPTH))
      else $error("entry count above depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mtt_pkg::ST_IDLE) |-> !accept)
      else $error("command accepted while busy");
   a_start_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtt_pkg::ST_WRITE) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("start did not add an entry");

endmodule

[rtl/mtt_mem.sv]
module mtt_mem #(
   parameter int Depth = mtt_pkg::TableDepth,
   parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrW-1:0]    wr_addr,
   input  mtt_pkg::entry_type  wr_data,
   input  logic [AddrW-1:0]    rd_addr,
   output mtt_pkg::entry_type  rd_data
);

   mtt_pkg::entry_type mem [Depth];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
